FILE: sv/cob_pkg.sv
// Shared types, constants and helpers for the circle against oriented box contact block
package cob_pkg;

  // CORDIC: one rotation per register stage, plus a load stage and an output stage
  localparam int CORDIC_STAGES = 28;
  localparam int CORDIC_LAT    = CORDIC_STAGES + 2;
  // square root: one result bit per stage; divider: one quotient bit per stage
  localparam int SQRT_LAT      = 32;
  localparam int DIV_LAT       = 15;
  localparam int SIDE_LAT      = SQRT_LAT + DIV_LAT;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008218;
  localparam logic signed [31:0] TRIG_ONE    = 32'sd268435456;
  localparam logic signed [15:0] NORM_ONE    = 16'sd16384;
  localparam logic [30:0]        PEN_MAX     = 31'h7FFF_FFFF;
  localparam logic signed [63:0] ROUND_HALF  = 64'sd134217728;
  localparam int                 TRIG_SHIFT  = 28;

  localparam logic [31:0] ATAN_PHASE [CORDIC_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5
  };

  // sine and cosine, Q2.28
  typedef logic signed [29:0] trig_t;

  // clamp a CORDIC output to plus or minus one
  function automatic trig_t clamp_trig(input logic signed [31:0] v);
    logic signed [31:0] t;
    t = v;
    if (v > TRIG_ONE) t = TRIG_ONE;
    if (v < -TRIG_ONE) t = -TRIG_ONE;
    return trig_t'(t);
  endfunction

  // saturate to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] t;
    t = 32'(v);
    if (v > 35'sh0_7FFF_FFFF) t = 32'sh7FFF_FFFF;
    if (v < -35'sh0_8000_0000) t = 32'sh8000_0000;
    return t;
  endfunction

  // clamp a rotated normal component to plus or minus one in Q2.14
  function automatic logic signed [15:0] clamp_norm(input logic signed [19:0] v);
    logic signed [15:0] t;
    t = 16'(v);
    if (v > 20'(NORM_ONE)) t = NORM_ONE;
    if (v < -20'(NORM_ONE)) t = -NORM_ONE;
    return t;
  endfunction

endpackage

FILE: sv/cob_cordic.sv
// Pipelined CORDIC sine and cosine from a 32 bit phase word
module cob_cordic import cob_pkg::*; (
  input  logic        clk,
  input  logic [31:0] phase,
  output trig_t       cos_o,
  output trig_t       sin_o
);

  logic signed [31:0] x_r [CORDIC_STAGES+1];
  logic signed [31:0] y_r [CORDIC_STAGES+1];
  logic signed [31:0] z_r [CORDIC_STAGES+1];
  logic [1:0]         q_r [CORDIC_STAGES+1];
  trig_t              cos_r, sin_r;
  trig_t              xc_w, yc_w;

  // load the start vector and the phase within the quadrant
  always_ff @(posedge clk) begin
    x_r[0] <= CORDIC_GAIN;
    y_r[0] <= '0;
    z_r[0] <= {2'b00, phase[29:0]};
    q_r[0] <= phase[31:30];
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (!z_r[i][31]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - $signed(ATAN_PHASE[i]);
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + $signed(ATAN_PHASE[i]);
      end
      q_r[i+1] <= q_r[i];
    end
  end

  assign xc_w = clamp_trig(x_r[CORDIC_STAGES]);
  assign yc_w = clamp_trig(y_r[CORDIC_STAGES]);

  // clamp and fold the quadrant back in
  always_ff @(posedge clk) begin
    case (q_r[CORDIC_STAGES])
      2'd0: begin cos_r <= xc_w;  sin_r <= yc_w;  end
      2'd1: begin cos_r <= -yc_w; sin_r <= xc_w;  end
      2'd2: begin cos_r <= -xc_w; sin_r <= -yc_w; end
      default: begin cos_r <= yc_w; sin_r <= -xc_w; end
    endcase
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

FILE: sv/cob_sqrt.sv
// Pipelined floor square root, one root bit per stage
module cob_sqrt import cob_pkg::*; (
  input  logic        clk,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  logic [35:0] rem_r  [SQRT_LAT];
  logic [31:0] root_r [SQRT_LAT];
  logic [63:0] v_r    [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_st
    logic [35:0] rem_in, rem2, trial;
    logic [31:0] root_in;
    logic [63:0] v_in;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = radicand;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign v_in    = v_r[k-1];
    end
    // bring down two radicand bits and try the next root bit
    assign rem2  = {rem_in[33:0], v_in[63:62]};
    assign trial = {2'b00, root_in, 2'b01};
    always_ff @(posedge clk) begin
      if (rem2 >= trial) begin
        rem_r[k]  <= rem2 - trial;
        root_r[k] <= {root_in[30:0], 1'b1};
      end else begin
        rem_r[k]  <= rem2;
        root_r[k] <= {root_in[30:0], 1'b0};
      end
      v_r[k] <= {v_in[61:0], 2'b00};
    end
  end

  assign root = root_r[SQRT_LAT-1];

endmodule

FILE: sv/cob_div.sv
// Pipelined restoring divider for the normal components, one quotient bit per stage
module cob_div import cob_pkg::*; (
  input  logic        clk,
  input  logic [46:0] num,
  input  logic [31:0] den,
  output logic [14:0] quo,
  output logic [31:0] den_o
);

  logic [46:0] rem_r [DIV_LAT];
  logic [31:0] den_r [DIV_LAT];
  logic [14:0] q_r   [DIV_LAT];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_st
    logic [46:0] rem_in, sub;
    logic [31:0] den_in;
    logic [14:0] q_in;
    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
    end
    // subtract the shifted divisor where it fits
    assign sub = 47'(den_in) << (DIV_LAT - 1 - k);
    always_ff @(posedge clk) begin
      if (rem_in >= sub) begin
        rem_r[k] <= rem_in - sub;
        q_r[k]   <= {q_in[13:0], 1'b1};
      end else begin
        rem_r[k] <= rem_in;
        q_r[k]   <= {q_in[13:0], 1'b0};
      end
      den_r[k] <= den_in;
    end
  end

  assign quo   = q_r[DIV_LAT-1];
  assign den_o = den_r[DIV_LAT-1];

endmodule

FILE: sv/circle_oriented_box_contact.sv
// Top level: circle against rotated box contact, fully pipelined
//
//  channel  ports                       direction  handshake
//  input    start, busy, in_*           in         word taken when start && !busy
//  result   out_valid, out_*            out        word shown for one cycle, no back-pressure
//
//  One word enters per cycle; busy is always low.
//  A word passes through the CORDIC, six geometry stages, the square root, the normal
//  dividers and the final stages that pick, rotate to world and round the normal.
//  Reset clears the valid bits only; words in flight at reset are dropped.
//  The receiver cannot stall, so the pipeline never holds.
module circle_oriented_box_contact import cob_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int ANGLE_BITS      = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    in_circle_center_x,
  input  logic signed [31:0]    in_circle_center_y,
  input  logic [30:0]           in_circle_radius,
  input  logic signed [31:0]    in_box_center_x,
  input  logic signed [31:0]    in_box_center_y,
  input  logic [30:0]           in_box_half_width,
  input  logic [30:0]           in_box_half_height,
  input  logic [ANGLE_BITS-1:0] in_box_angle,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic signed [15:0]    out_normal_x,
  output logic signed [15:0]    out_normal_y,
  output logic [30:0]           out_penetration,
  output logic signed [31:0]    out_contact_x,
  output logic signed [31:0]    out_contact_y
);

  localparam longint unsigned TINY_SQ =
    ((64'd1 << (2 * COORD_FRAC_BITS)) + 64'd5000) / 64'd10000;
  localparam int PIPE_LAT = CORDIC_LAT + 6 + SIDE_LAT + 3;

  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [30:0]        r;
    logic [30:0]        hw;
    logic [30:0]        hh;
    logic signed [31:0] bx;
    logic signed [31:0] by;
  } geo_t;

  typedef struct packed {
    logic               nohit;
    logic               small_d;
    logic [30:0]        magx;
    logic [30:0]        magy;
    logic               negx;
    logic               negy;
    logic signed [15:0] flnx;
    logic signed [15:0] flny;
    logic signed [37:0] fpen;
    logic [30:0]        r;
    trig_t              c;
    trig_t              s;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } side_t;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------------------------------------------------------- CORDIC
  logic [31:0] phase_w;
  trig_t       cos_w, sin_w;
  assign phase_w = {in_box_angle, {(32 - ANGLE_BITS){1'b0}}};

  cob_cordic u_cordic (.clk(clk), .phase(phase_w), .cos_o(cos_w), .sin_o(sin_w));

  // hold geometry alongside the CORDIC
  geo_t                  geo_r [CORDIC_LAT];
  logic [CORDIC_LAT-1:0] vld_geo_r;
  geo_t                  g_w;

  always_ff @(posedge clk) begin
    geo_r[0].dx <= 33'(in_circle_center_x) - 33'(in_box_center_x);
    geo_r[0].dy <= 33'(in_circle_center_y) - 33'(in_box_center_y);
    geo_r[0].r  <= in_circle_radius;
    geo_r[0].hw <= in_box_half_width;
    geo_r[0].hh <= in_box_half_height;
    geo_r[0].bx <= in_box_center_x;
    geo_r[0].by <= in_box_center_y;
    for (int k = 1; k < CORDIC_LAT; k++) geo_r[k] <= geo_r[k-1];
  end
  assign g_w = geo_r[CORDIC_LAT-1];

  // ---------------------------------------------------------------- M1: rotate into box space
  logic signed [62:0] p_dxc_r, p_dys_r, p_dyc_r, p_dxs_r;
  geo_t               g_m1_r;
  trig_t              c_m1_r, s_m1_r;
  logic               vld_m1_r;

  always_ff @(posedge clk) begin
    p_dxc_r <= g_w.dx * cos_w;
    p_dys_r <= g_w.dy * sin_w;
    p_dyc_r <= g_w.dy * cos_w;
    p_dxs_r <= g_w.dx * sin_w;
    g_m1_r  <= g_w;
    c_m1_r  <= cos_w;
    s_m1_r  <= sin_w;
  end

  // ---------------------------------------------------------------- M2: round to box coordinates
  logic signed [63:0] sx_w, sy_w;
  logic signed [35:0] lx_m2_r, ly_m2_r;
  geo_t               g_m2_r;
  trig_t              c_m2_r, s_m2_r;
  logic               vld_m2_r;

  assign sx_w = 64'(p_dxc_r) + 64'(p_dys_r) + ROUND_HALF;
  assign sy_w = 64'(p_dyc_r) - 64'(p_dxs_r) + ROUND_HALF;

  always_ff @(posedge clk) begin
    lx_m2_r <= 36'(sx_w >>> TRIG_SHIFT);
    ly_m2_r <= 36'(sy_w >>> TRIG_SHIFT);
    g_m2_r  <= g_m1_r;
    c_m2_r  <= c_m1_r;
    s_m2_r  <= s_m1_r;
  end

  // ---------------------------------------------------------------- M3: clamp to the box
  logic signed [35:0] hw36_w, hh36_w, px36_w, py36_w, ex36_w, ey36_w;
  logic signed [36:0] hw37_w, hh37_w;
  logic signed [31:0] px_m3_r, py_m3_r, ex_m3_r, ey_m3_r;
  logic signed [36:0] dr_m3_r, dl_m3_r, dt_m3_r, db_m3_r;
  logic               far_m3_r;
  logic [30:0]        r_m3_r;
  logic signed [31:0] bx_m3_r, by_m3_r;
  trig_t              c_m3_r, s_m3_r;
  logic               vld_m3_r;

  assign hw36_w = $signed({5'b0, g_m2_r.hw});
  assign hh36_w = $signed({5'b0, g_m2_r.hh});
  assign hw37_w = $signed({6'b0, g_m2_r.hw});
  assign hh37_w = $signed({6'b0, g_m2_r.hh});
  assign px36_w = (lx_m2_r > hw36_w) ? hw36_w : ((lx_m2_r < -hw36_w) ? -hw36_w : lx_m2_r);
  assign py36_w = (ly_m2_r > hh36_w) ? hh36_w : ((ly_m2_r < -hh36_w) ? -hh36_w : ly_m2_r);
  assign ex36_w = lx_m2_r - px36_w;
  assign ey36_w = ly_m2_r - py36_w;

  always_ff @(posedge clk) begin
    px_m3_r  <= 32'(px36_w);
    py_m3_r  <= 32'(py36_w);
    ex_m3_r  <= 32'(ex36_w);
    ey_m3_r  <= 32'(ey36_w);
    far_m3_r <= (ex36_w >= 36'sh0_8000_0000) || (ex36_w <= -36'sh0_8000_0000) ||
                (ey36_w >= 36'sh0_8000_0000) || (ey36_w <= -36'sh0_8000_0000);
    dr_m3_r  <= hw37_w - 37'(lx_m2_r);
    dl_m3_r  <= hw37_w + 37'(lx_m2_r);
    dt_m3_r  <= hh37_w - 37'(ly_m2_r);
    db_m3_r  <= hh37_w + 37'(ly_m2_r);
    r_m3_r   <= g_m2_r.r;
    bx_m3_r  <= g_m2_r.bx;
    by_m3_r  <= g_m2_r.by;
    c_m3_r   <= c_m2_r;
    s_m3_r   <= s_m2_r;
  end

  // ---------------------------------------------------------------- M4: squares, face pick, point rotation
  logic signed [36:0] fd_w;
  logic signed [15:0] flnx_w, flny_w;
  logic [62:0]        exsq_m4_r, eysq_m4_r;
  logic [61:0]        rsq_m4_r;
  logic signed [61:0] pxc_m4_r, pys_m4_r, pxs_m4_r, pyc_m4_r;
  logic signed [15:0] flnx_m4_r, flny_m4_r;
  logic signed [37:0] fpen_m4_r;
  logic               far_m4_r, negx_m4_r, negy_m4_r;
  logic [30:0]        magx_m4_r, magy_m4_r, r_m4_r;
  logic signed [31:0] bx_m4_r, by_m4_r;
  trig_t              c_m4_r, s_m4_r;
  logic               vld_m4_r;
  logic signed [63:0] exsq_w, eysq_w;

  // nearest face, ties going to the later face
  always_comb begin
    if (dr_m3_r < dl_m3_r && dr_m3_r < dt_m3_r && dr_m3_r < db_m3_r) begin
      flnx_w = NORM_ONE;  flny_w = '0;        fd_w = dr_m3_r;
    end else if (dl_m3_r < dt_m3_r && dl_m3_r < db_m3_r) begin
      flnx_w = -NORM_ONE; flny_w = '0;        fd_w = dl_m3_r;
    end else if (dt_m3_r < db_m3_r) begin
      flnx_w = '0;        flny_w = NORM_ONE;  fd_w = dt_m3_r;
    end else begin
      flnx_w = '0;        flny_w = -NORM_ONE; fd_w = db_m3_r;
    end
  end

  assign exsq_w = ex_m3_r * ex_m3_r;
  assign eysq_w = ey_m3_r * ey_m3_r;

  always_ff @(posedge clk) begin
    exsq_m4_r <= exsq_w[62:0];
    eysq_m4_r <= eysq_w[62:0];
    rsq_m4_r  <= r_m3_r * r_m3_r;
    pxc_m4_r  <= px_m3_r * c_m3_r;
    pys_m4_r  <= py_m3_r * s_m3_r;
    pxs_m4_r  <= px_m3_r * s_m3_r;
    pyc_m4_r  <= py_m3_r * c_m3_r;
    flnx_m4_r <= flnx_w;
    flny_m4_r <= flny_w;
    fpen_m4_r <= $signed({7'b0, r_m3_r}) + 38'(fd_w);
    far_m4_r  <= far_m3_r;
    negx_m4_r <= ex_m3_r[31];
    negy_m4_r <= ey_m3_r[31];
    magx_m4_r <= ex_m3_r[31] ? 31'(-ex_m3_r) : ex_m3_r[30:0];
    magy_m4_r <= ey_m3_r[31] ? 31'(-ey_m3_r) : ey_m3_r[30:0];
    r_m4_r    <= r_m3_r;
    bx_m4_r   <= bx_m3_r;
    by_m4_r   <= by_m3_r;
    c_m4_r    <= c_m3_r;
    s_m4_r    <= s_m3_r;
  end

  // ---------------------------------------------------------------- M5: distance squared, point rounding
  logic signed [63:0] cxs_w, cys_w;
  logic [63:0]        dsq_m5_r;
  logic signed [33:0] cxr_m5_r, cyr_m5_r;
  side_t              sd_m5_r;
  logic [61:0]        rsq_m5_r;
  logic               far_m5_r;
  logic signed [31:0] bx_m5_r, by_m5_r;
  logic               vld_m5_r;

  assign cxs_w = 64'(pxc_m4_r) - 64'(pys_m4_r) + ROUND_HALF;
  assign cys_w = 64'(pxs_m4_r) + 64'(pyc_m4_r) + ROUND_HALF;

  always_ff @(posedge clk) begin
    dsq_m5_r      <= 64'(exsq_m4_r) + 64'(eysq_m4_r);
    cxr_m5_r      <= 34'(cxs_w >>> TRIG_SHIFT);
    cyr_m5_r      <= 34'(cys_w >>> TRIG_SHIFT);
    rsq_m5_r      <= rsq_m4_r;
    far_m5_r      <= far_m4_r;
    bx_m5_r       <= bx_m4_r;
    by_m5_r       <= by_m4_r;
    sd_m5_r.nohit   <= 1'b0;
    sd_m5_r.small_d <= 1'b0;
    sd_m5_r.magx  <= magx_m4_r;
    sd_m5_r.magy  <= magy_m4_r;
    sd_m5_r.negx  <= negx_m4_r;
    sd_m5_r.negy  <= negy_m4_r;
    sd_m5_r.flnx  <= flnx_m4_r;
    sd_m5_r.flny  <= flny_m4_r;
    sd_m5_r.fpen  <= fpen_m4_r;
    sd_m5_r.r     <= r_m4_r;
    sd_m5_r.c     <= c_m4_r;
    sd_m5_r.s     <= s_m4_r;
    sd_m5_r.cx    <= '0;
    sd_m5_r.cy    <= '0;
  end

  // ---------------------------------------------------------------- M6: hit test, contact offset
  side_t       sd_m6_nxt, sd_m6_r;
  logic [63:0] dsq_m6_r;
  logic        vld_m6_r;

  // fill in the hit flags and the world contact point
  always_comb begin
    sd_m6_nxt         = sd_m5_r;
    sd_m6_nxt.nohit   = far_m5_r || (dsq_m5_r > {2'b00, rsq_m5_r});
    sd_m6_nxt.small_d = (dsq_m5_r <= TINY_SQ);
    sd_m6_nxt.cx      = sat32(35'(cxr_m5_r) + 35'(bx_m5_r));
    sd_m6_nxt.cy      = sat32(35'(cyr_m5_r) + 35'(by_m5_r));
  end

  always_ff @(posedge clk) begin
    sd_m6_r  <= sd_m6_nxt;
    dsq_m6_r <= dsq_m5_r;
  end

  // ---------------------------------------------------------------- square root and dividers
  side_t               side_r [SIDE_LAT];
  logic [SIDE_LAT-1:0] vld_side_r;
  side_t               sq_w, sd_w;
  logic [31:0]         root_w, dist_w;
  logic [46:0]         numx_w, numy_w;
  logic [14:0]         quox_w, quoy_w;

  cob_sqrt u_sqrt (.clk(clk), .radicand(dsq_m6_r), .root(root_w));

  always_ff @(posedge clk) begin
    side_r[0] <= sd_m6_r;
    for (int k = 1; k < SIDE_LAT; k++) side_r[k] <= side_r[k-1];
  end

  assign sq_w   = side_r[SQRT_LAT-1];
  assign numx_w = {2'b00, sq_w.magx, 14'b0} + {16'b0, root_w[31:1]};
  assign numy_w = {2'b00, sq_w.magy, 14'b0} + {16'b0, root_w[31:1]};

  cob_div u_divx (.clk(clk), .num(numx_w), .den(root_w), .quo(quox_w), .den_o(dist_w));
  cob_div u_divy (.clk(clk), .num(numy_w), .den(root_w), .quo(quoy_w), .den_o());

  // ---------------------------------------------------------------- F1: pick normal and depth
  logic signed [15:0] qx_w, qy_w, onx_w, ony_w;
  logic signed [37:0] pen38_w;
  logic signed [15:0] lnx_f1_r, lny_f1_r;
  logic [30:0]        pen_f1_r;
  logic               nohit_f1_r, vld_f1_r;
  trig_t              c_f1_r, s_f1_r;
  logic signed [31:0] cx_f1_r, cy_f1_r;

  assign sd_w    = side_r[SIDE_LAT-1];
  assign qx_w    = (quox_w > 15'(NORM_ONE)) ? NORM_ONE : $signed({1'b0, quox_w});
  assign qy_w    = (quoy_w > 15'(NORM_ONE)) ? NORM_ONE : $signed({1'b0, quoy_w});
  assign onx_w   = sd_w.negx ? qx_w : -qx_w;
  assign ony_w   = sd_w.negy ? qy_w : -qy_w;
  assign pen38_w = sd_w.small_d ? sd_w.fpen
                                : ($signed({7'b0, sd_w.r}) - $signed({6'b0, dist_w}));

  always_ff @(posedge clk) begin
    lnx_f1_r <= sd_w.small_d ? sd_w.flnx : onx_w;
    lny_f1_r <= sd_w.small_d ? sd_w.flny : ony_w;
    if (pen38_w < 0)                          pen_f1_r <= '0;
    else if (pen38_w > $signed({7'b0, PEN_MAX})) pen_f1_r <= PEN_MAX;
    else                                      pen_f1_r <= pen38_w[30:0];
    nohit_f1_r <= sd_w.nohit;
    c_f1_r     <= sd_w.c;
    s_f1_r     <= sd_w.s;
    cx_f1_r    <= sd_w.cx;
    cy_f1_r    <= sd_w.cy;
  end

  // ---------------------------------------------------------------- F2: rotate normal to world
  logic signed [45:0] nxc_f2_r, nys_f2_r, nxs_f2_r, nyc_f2_r;
  logic [30:0]        pen_f2_r;
  logic               nohit_f2_r, vld_f2_r;
  logic signed [31:0] cx_f2_r, cy_f2_r;

  always_ff @(posedge clk) begin
    nxc_f2_r   <= lnx_f1_r * c_f1_r;
    nys_f2_r   <= lny_f1_r * s_f1_r;
    nxs_f2_r   <= lnx_f1_r * s_f1_r;
    nyc_f2_r   <= lny_f1_r * c_f1_r;
    pen_f2_r   <= pen_f1_r;
    nohit_f2_r <= nohit_f1_r;
    cx_f2_r    <= cx_f1_r;
    cy_f2_r    <= cy_f1_r;
  end

  // ---------------------------------------------------------------- F3: round, clamp, drive result
  logic signed [63:0] wnx_w, wny_w;
  logic               out_valid_r, out_hit_r;
  logic signed [15:0] out_nx_r, out_ny_r;
  logic [30:0]        out_pen_r;
  logic signed [31:0] out_cx_r, out_cy_r;

  assign wnx_w = 64'(nxc_f2_r) - 64'(nys_f2_r) + ROUND_HALF;
  assign wny_w = 64'(nxs_f2_r) + 64'(nyc_f2_r) + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (nohit_f2_r) begin
      out_hit_r <= 1'b0;
      out_nx_r  <= '0;
      out_ny_r  <= '0;
      out_pen_r <= '0;
      out_cx_r  <= '0;
      out_cy_r  <= '0;
    end else begin
      out_hit_r <= 1'b1;
      out_nx_r  <= clamp_norm(20'(wnx_w >>> TRIG_SHIFT));
      out_ny_r  <= clamp_norm(20'(wny_w >>> TRIG_SHIFT));
      out_pen_r <= pen_f2_r;
      out_cx_r  <= cx_f2_r;
      out_cy_r  <= cy_f2_r;
    end
  end

  // ---------------------------------------------------------------- valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_geo_r   <= '0;
      vld_m1_r    <= 1'b0;
      vld_m2_r    <= 1'b0;
      vld_m3_r    <= 1'b0;
      vld_m4_r    <= 1'b0;
      vld_m5_r    <= 1'b0;
      vld_m6_r    <= 1'b0;
      vld_side_r  <= '0;
      vld_f1_r    <= 1'b0;
      vld_f2_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_geo_r   <= {vld_geo_r[CORDIC_LAT-2:0], accept};
      vld_m1_r    <= vld_geo_r[CORDIC_LAT-1];
      vld_m2_r    <= vld_m1_r;
      vld_m3_r    <= vld_m2_r;
      vld_m4_r    <= vld_m3_r;
      vld_m5_r    <= vld_m4_r;
      vld_m6_r    <= vld_m5_r;
      vld_side_r  <= {vld_side_r[SIDE_LAT-2:0], vld_m6_r};
      vld_f1_r    <= vld_side_r[SIDE_LAT-1];
      vld_f2_r    <= vld_f1_r;
      out_valid_r <= vld_f2_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_normal_x    = out_nx_r;
  assign out_normal_y    = out_ny_r;
  assign out_penetration = out_pen_r;
  assign out_contact_x   = out_cx_r;
  assign out_contact_y   = out_cy_r;

  // ---------------------------------------------------------------- assertions
  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_normal_x == 0 && out_normal_y == 0 &&
      out_penetration == 0 && out_contact_x == 0 && out_contact_y == 0)
    else $error("miss word carries non-zero fields");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_normal_x <= NORM_ONE && out_normal_x >= -NORM_ONE &&
      out_normal_y <= NORM_ONE && out_normal_y >= -NORM_ONE)
    else $error("world normal out of range");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, PIPE_LAT))
    else $error("result word without a matching start");

endmodule
